@@ hw/rtl/bqlp_pkg.sv @@
// ============================================================================
// bqlp_pkg: shared definitions of the biquad low-pass filter
// Widths, coefficient reset values, configuration register indexes and the
// structs that pass coefficients and filter history between modules.
// ============================================================================
package bqlp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int FRAC_BITS = 14;
    // Five products of at most 2^31 in magnitude fit well within this width.
    localparam int ACC_W     = SAMPLE_W + COEF_W + 4;
    localparam int SHR_W     = ACC_W - FRAC_BITS;

    localparam int SAT_MAX   = (2 ** (SAMPLE_W - 1)) - 1;
    localparam int SAT_MIN   = -(2 ** (SAMPLE_W - 1));

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_B_OUTER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A_SECOND = 2'd2;

    localparam logic signed [COEF_W-1:0] COEF_B_RESET  = 16'sd1105;
    localparam logic signed [COEF_W-1:0] COEF_A1_RESET = 16'sd18727;
    localparam logic signed [COEF_W-1:0] COEF_A2_RESET = -16'sd6763;

    typedef struct packed {
        logic signed [COEF_W-1:0] b_outer;
        logic signed [COEF_W-1:0] a_first;
        logic signed [COEF_W-1:0] a_second;
    } t_coefs;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
    } t_hist;

endpackage

@@ hw/rtl/bqlp_in_if.sv @@
// ============================================================================
// bqlp_in_if: input sample channel
// Valid/ready channel that carries one input sample and its end-of-block flag.
// ============================================================================
interface bqlp_in_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [bqlp_pkg::SAMPLE_W-1:0] sample_in;
    logic                                 is_last;

    modport source (output valid, output sample_in, output is_last, input ready);
    modport sink   (input valid, input sample_in, input is_last, output ready);

endinterface

@@ hw/rtl/bqlp_out_if.sv @@
// ============================================================================
// bqlp_out_if: output sample channel
// Valid/ready channel that carries one filtered sample and its final flag.
// ============================================================================
interface bqlp_out_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [bqlp_pkg::SAMPLE_W-1:0] sample_out;
    logic                                 is_final;

    modport source (output valid, output sample_out, output is_final, input ready);
    modport sink   (input valid, input sample_out, input is_final, output ready);

endinterface

@@ hw/rtl/bqlp_datapath.sv @@
// ============================================================================
// bqlp_datapath: biquad multiply-accumulate, jamming and saturation
// Forms the direct form I sum, shifts out the fraction with a sticky LSB and
// clamps the result to the sample range.
// ============================================================================
module bqlp_datapath (
    input  bqlp_pkg::t_coefs                    i_coefs,
    input  bqlp_pkg::t_hist                     i_hist,
    input  logic signed [bqlp_pkg::SAMPLE_W-1:0] i_x,
    output logic signed [bqlp_pkg::SAMPLE_W-1:0] o_y
);

    localparam int ACC_W = bqlp_pkg::ACC_W;
    localparam int SHR_W = bqlp_pkg::SHR_W;
    localparam int PRD_W = bqlp_pkg::SAMPLE_W + bqlp_pkg::COEF_W;

    localparam logic signed [SHR_W-1:0] SMAX = SHR_W'(bqlp_pkg::SAT_MAX);
    localparam logic signed [SHR_W-1:0] SMIN = SHR_W'(bqlp_pkg::SAT_MIN);

    logic signed [PRD_W-1:0] w_p_x0;
    logic signed [PRD_W-1:0] w_p_x1;
    logic signed [PRD_W-1:0] w_p_x2;
    logic signed [PRD_W-1:0] w_p_y1;
    logic signed [PRD_W-1:0] w_p_y2;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [SHR_W-1:0] w_shr;
    logic signed [SHR_W-1:0] w_jam;
    logic                    w_sticky;

    assign w_p_x0 = i_coefs.b_outer  * i_x;
    assign w_p_x1 = i_coefs.b_outer  * i_hist.x1;
    assign w_p_x2 = i_coefs.b_outer  * i_hist.x2;
    assign w_p_y1 = i_coefs.a_first  * i_hist.y1;
    assign w_p_y2 = i_coefs.a_second * i_hist.y2;

    // The middle tap carries twice the outer coefficient, hence the shift.
    assign w_acc = ACC_W'(w_p_x0) + (ACC_W'(w_p_x1) <<< 1) + ACC_W'(w_p_x2)
                 + ACC_W'(w_p_y1) + ACC_W'(w_p_y2);

    assign w_shr    = w_acc[ACC_W-1:bqlp_pkg::FRAC_BITS];
    assign w_sticky = |w_acc[bqlp_pkg::FRAC_BITS-1:0];
    assign w_jam    = {w_shr[SHR_W-1:1], w_shr[0] | w_sticky};

    always_comb begin
        if (w_jam > SMAX) begin
            o_y = SMAX[bqlp_pkg::SAMPLE_W-1:0];
        end else if (w_jam < SMIN) begin
            o_y = SMIN[bqlp_pkg::SAMPLE_W-1:0];
        end else begin
            o_y = w_jam[bqlp_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

@@ hw/rtl/biquad_lowpass_iir_q14.sv @@
// ============================================================================
// biquad_lowpass_iir_q14: second-order low-pass IIR filter, Q14 coefficients
// Direct form I biquad with jamming rounding and a saturated feedback path.
// ============================================================================
// Samples arrive on the i_in channel and filtered samples leave on o_out,
// both valid/ready; an item moves at a rising edge where valid and ready are
// both high. Every input item yields exactly one output item, in order.
//
// An accepted item is held in an input register. Once the output register is
// empty or being emptied, the five products, the sum, the shift with sticky
// LSB and the clamp are worked out in one pass and written to the output
// register, together with the new filter history, and o_out.valid rises.
// Throughput is one item per cycle while the receiver does not stall: the
// history registers feed back through the combinational datapath alone, so
// nothing else limits the rate.
//
// If the receiver stalls, the result waits in the output register and one
// further item is still taken into the input register; only then does
// i_in.ready fall. After an item flagged is_last, the history returns to
// zero so that the next item starts a fresh block.
//
// Reset (synchronous, active low) empties both registers, clears the history
// and restores the default Butterworth coefficients. The coefficient port
// i_cfg_we/i_cfg_idx/i_cfg_data should be written only while the block is
// idle; an index beyond the three registers is ignored.
// ============================================================================
module biquad_lowpass_iir_q14 (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    bqlp_in_if.sink                               i_in,
    bqlp_out_if.source                            o_out,
    input  logic                                  i_cfg_we,
    input  logic [bqlp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic signed [bqlp_pkg::COEF_W-1:0]    i_cfg_data
);

    // Coefficient registers.
    bqlp_pkg::t_coefs r_coefs;

    // Input register: the item waiting to be filtered.
    logic                                 r_in_valid;
    logic signed [bqlp_pkg::SAMPLE_W-1:0] r_in_x;
    logic                                 r_in_last;

    // Filter history, updated as each item passes through the datapath.
    bqlp_pkg::t_hist r_hist;
    bqlp_pkg::t_hist n_hist;

    // Output register.
    logic                                 r_out_valid;
    logic signed [bqlp_pkg::SAMPLE_W-1:0] r_out_y;
    logic                                 r_out_last;

    logic                                 w_adv;
    logic signed [bqlp_pkg::SAMPLE_W-1:0] w_y;

    // The held item moves on whenever the output register is empty or is
    // being emptied in this cycle.
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_y;
    assign o_out.is_final   = r_out_last;

    bqlp_datapath u_datapath (
        .i_coefs (r_coefs),
        .i_hist  (r_hist),
        .i_x     (r_in_x),
        .o_y     (w_y)
    );

    always_comb begin
        if (r_in_last) begin
            n_hist = '0;
        end else begin
            n_hist.x1 = r_in_x;
            n_hist.x2 = r_hist.x1;
            n_hist.y1 = w_y;
            n_hist.y2 = r_hist.y1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b_outer  <= bqlp_pkg::COEF_B_RESET;
            r_coefs.a_first  <= bqlp_pkg::COEF_A1_RESET;
            r_coefs.a_second <= bqlp_pkg::COEF_A2_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bqlp_pkg::CFG_B_OUTER:  r_coefs.b_outer  <= i_cfg_data;
                bqlp_pkg::CFG_A_FIRST:  r_coefs.a_first  <= i_cfg_data;
                bqlp_pkg::CFG_A_SECOND: r_coefs.a_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hist      <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_hist      <= n_hist;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_x    <= i_in.sample_in;
            r_in_last <= i_in.is_last;
        end
        if (w_adv) begin
            r_out_y    <= w_y;
            r_out_last <= r_in_last;
        end
    end

    // An item leaving the input register always lands in the output register.
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("output register not filled after an advance");

    // An end-of-block item leaves a clean history behind it.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_hist == '0))
        else $error("history not cleared after the last item of a block");

    // Otherwise the history shifts by one sample.
    a_hist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_last) |=> (r_hist.x1 == $past(r_in_x)
                                   && r_hist.y2 == $past(r_hist.y1)
                                   && r_hist.y1 == r_out_y))
        else $error("history did not shift with the processed item");

    // With both registers full and the receiver stalled, nothing more is taken.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while both registers are occupied");

    // Reset brings back the default coefficients.
    a_reset_coefs: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_coefs.b_outer == bqlp_pkg::COEF_B_RESET
                      && r_coefs.a_first == bqlp_pkg::COEF_A1_RESET
                      && r_coefs.a_second == bqlp_pkg::COEF_A2_RESET))
        else $error("coefficients not restored by reset");

endmodule

@@ verif/biquad_lowpass_iir_q14_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// biquad_lowpass_iir_q14_test: self-checking bench of the biquad low-pass
// A short table of directed samples and coefficient writes is followed by
// random phases under fresh coefficient sets. A bit-exact model of the filter
// inside the bench predicts every output item, and a monitor compares each one
// with the oldest prediction while both channels idle and stall at random.
// ============================================================================
module biquad_lowpass_iir_q14_test;

    import bqlp_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int TIMEOUT_CYCLES = 300000;
    // The tail after the last expected output leaves ample margin.
    localparam int DRAIN_CYCLES   = 10;
    localparam int RAND_PHASES    = 9;
    localparam int PRESSURE_PHASE = 3;
    localparam int LONG_HOLD      = 400;
    localparam int MAX_BURST      = 24;
    localparam int MAX_GAP        = 10;
    localparam int N_DIRECTED     = 36;

    // Index that lies beyond the three coefficient registers; writes to it
    // must leave the filter untouched.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;

    typedef enum logic {ROW_SAMPLE, ROW_COEF} row_kind_e;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_RARE_STALL} rx_mode_e;

    typedef enum int {PROF_DEFAULT, PROF_STABLE, PROF_EXTREME, PROF_ANY} coef_profile_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        int                    value;
        bit                    last;
        bit                    typed;
        int                    want;
    } stim_row_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       is_final;
    } filt_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic signed [COEF_W-1:0]   i_cfg_data;

    bqlp_in_if  in_ch ();
    bqlp_out_if out_ch ();

    biquad_lowpass_iir_q14 DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Filter model: the bench's own copy of coefficients and history.
    // ------------------------------------------------------------------------
    logic signed [COEF_W-1:0]   coef_b  = COEF_B_RESET;
    logic signed [COEF_W-1:0]   coef_a1 = COEF_A1_RESET;
    logic signed [COEF_W-1:0]   coef_a2 = COEF_A2_RESET;
    logic signed [SAMPLE_W-1:0] hist_x1 = '0;
    logic signed [SAMPLE_W-1:0] hist_x2 = '0;
    logic signed [SAMPLE_W-1:0] hist_y1 = '0;
    logic signed [SAMPLE_W-1:0] hist_y2 = '0;

    // Filtered samples still owed by the block, oldest first.
    filt_result_t pending_outputs[$];

    int mismatch_count = 0;
    int output_count   = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    // The main process asks for a long receiver hold-off by raising the
    // request count; the receiver serves each request once.
    int hold_requests  = 0;
    int holds_served   = 0;

    // One sample through the direct form I biquad. The sum is floored by the
    // fractional shift, the LSB is jammed to one when any discarded bit is
    // set, and only then is the value clamped to the sample range. The
    // clamped value is what feeds back. A sample flagged last clears the
    // history so the next one starts a fresh block.
    function automatic filt_result_t filter_step(input logic signed [SAMPLE_W-1:0] x,
                                                 input logic last);
        longint       acc;
        longint       y;
        filt_result_t r;
        acc = longint'(coef_b) * longint'(x)
            + 2 * longint'(coef_b) * longint'(hist_x1)
            + longint'(coef_b) * longint'(hist_x2)
            + longint'(coef_a1) * longint'(hist_y1)
            + longint'(coef_a2) * longint'(hist_y2);
        y = acc >>> FRAC_BITS;
        if (acc[FRAC_BITS-1:0] != '0) begin
            y[0] = 1'b1;
        end
        if (y > longint'(SAT_MAX)) begin
            y = longint'(SAT_MAX);
        end
        if (y < longint'(SAT_MIN)) begin
            y = longint'(SAT_MIN);
        end
        r.sample   = y[SAMPLE_W-1:0];
        r.is_final = last;
        if (last) begin
            hist_x1 = '0;
            hist_x2 = '0;
            hist_y1 = '0;
            hist_y2 = '0;
        end else begin
            hist_x2 = hist_x1;
            hist_x1 = x;
            hist_y2 = hist_y1;
            hist_y1 = r.sample;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Offers one sample and waits for the item to be taken. Valid is left high
    // so that a following item goes back to back; the pacing task lowers it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic last,
                               input bit typed, input int want);
        filt_result_t r;
        i_cfg_we        <= 1'b0;
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= x;
        in_ch.is_last   <= last;
        do begin
            @(posedge i_clk);
        end while (in_ch.ready !== 1'b1);
        r = filter_step(x, last);
        // Rows of the directed table that carry a hand-worked answer are
        // checked against that answer instead of the model.
        if (typed) begin
            r.sample = SAMPLE_W'(want);
        end
        pending_outputs.push_back(r);
    endtask

    // Bursts of random length, each followed by a random gap; about a
    // quarter of bursts run straight into the next with no gap at all.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            burst_left = $urandom_range(1, MAX_BURST);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Coefficients change only once the block has handed back every item it
    // took, so no sample in flight sees a half-updated set.
    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
                              input logic signed [COEF_W-1:0] data);
        in_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_B_OUTER:  coef_b  = data;
            CFG_A_FIRST:  coef_a1 = data;
            CFG_A_SECOND: coef_a2 = data;
            default: ;
        endcase
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coef(input coef_profile_e prof,
                                                           input int dflt);
        case (prof)
            PROF_DEFAULT: return COEF_W'(dflt);
            PROF_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return COEF_W'(SAT_MAX);
                    1:       return COEF_W'(SAT_MIN);
                    2:       return '0;
                    default: return COEF_W'($urandom());
                endcase
            end
            default: return COEF_W'($urandom());
        endcase
    endfunction

    // A new coefficient set for a random phase. The stable profile draws a small
    // outer gain, a positive first and a negative second feedback coefficient; the
    // default profile restores the reset values, and the others drive the filter hard into saturation.
    task automatic program_coefs();
        coef_profile_e prof;
        prof = coef_profile_e'($urandom_range(0, 3));
        if (prof == PROF_STABLE) begin
            write_coef(CFG_B_OUTER,  COEF_W'($urandom_range(0, 2500)));
            write_coef(CFG_A_FIRST,  COEF_W'($urandom_range(0, 30000)));
            write_coef(CFG_A_SECOND, COEF_W'(-$signed($urandom_range(0, 14000))));
        end else begin
            write_coef(CFG_B_OUTER,  pick_coef(prof, COEF_B_RESET));
            write_coef(CFG_A_FIRST,  pick_coef(prof, COEF_A1_RESET));
            write_coef(CFG_A_SECOND, pick_coef(prof, COEF_A2_RESET));
        end
        if ($urandom_range(0, 2) == 0) begin
            write_coef(CFG_IDX_NONE, COEF_W'($urandom()));
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_W'(SAT_MAX);
            1:       return SAMPLE_W'(SAT_MIN);
            2:       return SAMPLE_W'($signed($urandom_range(0, 64)) - 32);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed table. Samples after reset or after an end of block start from
    // zero history, which makes a few answers plain: zero in gives zero out,
    // a unity gain passes a sample through exactly, and full-scale gains
    // saturate. The rest are left to the model. The table also covers the
    // jammed LSB on a tiny sum, all three coefficients at their negative
    // extreme, and a write to an index beyond the registers.
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_SAMPLE, CFG_B_OUTER,  0,      1'b0, 1'b1, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  32767,  1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  -32768, 1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  12345,  1'b1, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  0,      1'b0, 1'b1, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  -1,     1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  1,      1'b1, 1'b0, 0},
        '{ROW_COEF,   CFG_B_OUTER,  16384,  1'b0, 1'b0, 0},
        '{ROW_COEF,   CFG_A_FIRST,  0,      1'b0, 1'b0, 0},
        '{ROW_COEF,   CFG_A_SECOND, 0,      1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  -32768, 1'b0, 1'b1, -32768},
        '{ROW_SAMPLE, CFG_B_OUTER,  32767,  1'b1, 1'b0, 0},
        '{ROW_COEF,   CFG_B_OUTER,  32767,  1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  32767,  1'b1, 1'b1, 32767},
        '{ROW_SAMPLE, CFG_B_OUTER,  -32768, 1'b1, 1'b1, -32768},
        '{ROW_COEF,   CFG_B_OUTER,  -32768, 1'b0, 1'b0, 0},
        '{ROW_COEF,   CFG_A_FIRST,  -32768, 1'b0, 1'b0, 0},
        '{ROW_COEF,   CFG_A_SECOND, -32768, 1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  -32768, 1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  -32768, 1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  32767,  1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  32767,  1'b1, 1'b0, 0},
        '{ROW_COEF,   CFG_IDX_NONE, 4660,   1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  100,    1'b0, 1'b0, 0},
        '{ROW_COEF,   CFG_B_OUTER,  1,      1'b0, 1'b0, 0},
        '{ROW_COEF,   CFG_A_FIRST,  32767,  1'b0, 1'b0, 0},
        '{ROW_COEF,   CFG_A_SECOND, 0,      1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  3,      1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  0,      1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  -3,     1'b1, 1'b0, 0},
        '{ROW_COEF,   CFG_B_OUTER,  1105,   1'b0, 1'b0, 0},
        '{ROW_COEF,   CFG_A_FIRST,  18727,  1'b0, 1'b0, 0},
        '{ROW_COEF,   CFG_A_SECOND, -6763,  1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  16384,  1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  16384,  1'b0, 1'b0, 0},
        '{ROW_SAMPLE, CFG_B_OUTER,  16384,  1'b1, 1'b0, 0}
    };

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table, then the random phases.
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        int n_items;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_B_OUTER;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        in_ch.is_last   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_COEF) begin
                write_coef(directed_rows[r].idx, COEF_W'(directed_rows[r].value));
            end else begin
                send_sample(SAMPLE_W'(directed_rows[r].value), directed_rows[r].last,
                            directed_rows[r].typed, directed_rows[r].want);
                pace_sender();
            end
        end

        // Each phase opens with a fresh coefficient set (the first keeps the
        // defaults restored by the table) and then streams blocks of random
        // length; roughly one item in twelve closes a block. In the pressure
        // phase the receiver holds off for a long stretch while items keep
        // coming, so the block fills up and must hold its input back.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase != 0) begin
                program_coefs();
            end
            if (phase == PRESSURE_PHASE) begin
                hold_requests++;
            end
            n_items = $urandom_range(95, 130);
            for (int k = 0; k < n_items; k++) begin
                send_sample(random_sample(), ($urandom_range(0, 11) == 0), 1'b0, 0);
                pace_sender();
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: a ready pattern of its own, switching at random between
    // always ready, a fair coin, mostly stalled and rarely stalled. A pending
    // hold-off request overrides the pattern for a long stretch.
    // ------------------------------------------------------------------------
    initial begin : receiver
        rx_mode_e mode;
        int       mode_left;
        int       hold_left;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 120);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:     out_ch.ready <= 1'b1;
                    RX_COIN:       out_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE:     out_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_RARE_STALL: out_ch.ready <= ($urandom_range(0, 7) != 0);
                    default:       out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output checking: every item taken from the block is matched with the
    // oldest prediction, field by field.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("%0t ns: output %0d %s: got %0d, expected %0d",
                 $time, output_count, what, got, want);
    endtask

    always @(posedge i_clk) begin
        filt_result_t want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch("arrived with nothing outstanding",
                                longint'(out_ch.sample_out), 0);
            end else begin
                want = pending_outputs.pop_front();
                if (out_ch.sample_out !== want.sample) begin
                    report_mismatch("sample_out", longint'(out_ch.sample_out),
                                    longint'(want.sample));
                end
                if (out_ch.is_final !== want.is_final) begin
                    report_mismatch("is_final", longint'(out_ch.is_final),
                                    longint'(want.is_final));
                end
            end
            output_count++;
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
